[sv/md5_pkg.sv]
// Shared types, constants and round tables for the MD5 digest block.
package md5_pkg;

  // Kind of a queue entry between the front and the back
  typedef enum logic {
    KIND_WORD  = 1'b0,
    KIND_FINAL = 1'b1
  } md5_kind_e;

  // One queue entry: a full word, or the last partial word of a message
  typedef struct packed {
    md5_kind_e   kind;
    logic [31:0] word;
    logic [1:0]  nbytes;
  } md5_entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_ROUND,
    BK_FOLD,
    BK_LENGTH,
    BK_OUTPUT
  } md5_back_state_e;

  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hefcd_ab89;
  localparam logic [31:0] IV_C = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D = 32'h1032_5476;

  localparam logic [31:0] PAD_BYTE     = 32'h0000_0080;
  localparam logic [3:0]  LEN_LO_WORD  = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD  = 4'd15;
  localparam logic [3:0]  LAST_WORD    = 4'd15;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;

  // Message word used by a round
  function automatic logic [3:0] md5_msg_index(logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = (r << 2) + r + 4'd1;
      2'd2:    g = (r << 1) + r + 4'd5;
      default: g = (r << 3) - r;
    endcase
    return g;
  endfunction

  // Left rotation of a round
  function automatic logic [4:0] md5_rot(logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Additive constant of a round
  function automatic logic [31:0] md5_round_const(logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Reverse the byte order of a word
  function automatic logic [31:0] md5_bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

[sv/md5_if.sv]
// Channel interfaces for message bytes in and digests out.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_front;
  logic [63:0] digest_back;

  modport source (output valid, digest_front, digest_back, input ready);
  modport sink   (input valid, digest_front, digest_back, output ready);
endinterface

[sv/md5_front.sv]
// Front end: packs message bytes into little-endian words and marks message ends.
module md5_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  md5_in_if.sink              in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output md5_pkg::md5_entry_t push_entry_o
);

  logic [23:0] acc_q, acc_d;
  logic [1:0]  nb_q, nb_d;
  logic        pend_q, pend_d;

  logic        accept;
  logic        word_full;
  logic [31:0] cur_word;
  logic [1:0]  nb_new;

  // Take a byte only when the queue can hold whatever it produces
  assign in_i.ready = push_ready_i && !pend_q;
  assign accept     = in_i.valid && in_i.ready;
  assign word_full  = in_i.byte_present && (nb_q == 2'd3);

  // Insert the byte into the partial word
  always_comb begin
    cur_word = {8'h00, acc_q};
    if (in_i.byte_present) begin
      cur_word[{nb_q, 3'b000} +: 8] = in_i.data_byte;
    end
    nb_new = in_i.byte_present ? nb_q + 2'd1 : nb_q;
  end

  // Build the queue entry
  always_comb begin
    push_valid_o        = 1'b0;
    push_entry_o.kind   = md5_pkg::KIND_WORD;
    push_entry_o.word   = cur_word;
    push_entry_o.nbytes = nb_new;
    if (pend_q) begin
      push_valid_o        = 1'b1;
      push_entry_o.kind   = md5_pkg::KIND_FINAL;
      push_entry_o.word   = '0;
      push_entry_o.nbytes = 2'd0;
    end else if (accept && word_full) begin
      push_valid_o        = 1'b1;
    end else if (accept && in_i.message_end) begin
      push_valid_o        = 1'b1;
      push_entry_o.kind   = md5_pkg::KIND_FINAL;
    end
  end

  // Advance the packing state
  always_comb begin
    acc_d  = acc_q;
    nb_d   = nb_q;
    pend_d = pend_q;
    if (pend_q && push_ready_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (word_full) begin
        nb_d   = 2'd0;
        pend_d = in_i.message_end;
      end else if (in_i.message_end) begin
        nb_d = 2'd0;
      end else begin
        acc_d = cur_word[23:0];
        nb_d  = nb_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q   <= 2'd0;
      pend_q <= 1'b0;
    end else begin
      nb_q   <= nb_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

[sv/md5_queue.sv]
// Short queue of packed words between the front and the back.
module md5_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  md5_pkg::md5_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output md5_pkg::md5_entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  md5_pkg::md5_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

[sv/md5_back.sv]
// Back end: block store, padding, 64-round compression and digest register.
module md5_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  md5_pkg::md5_entry_t pop_entry_i,
  md5_out_if.source           out_o
);

  md5_pkg::md5_back_state_e state_q, state_d;

  logic [31:0] store_q [16];
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] km_q;
  logic [5:0]  rnd_q;
  logic [3:0]  widx_q;
  logic [58:0] wcount_q;
  logic [63:0] len_q;
  logic        fin_q;
  logic        second_q;
  logic        out_valid_q;
  logic [63:0] out_front_q, out_back_q;

  logic        take;
  logic        out_load;
  logic [4:0]  pad_sh;
  logic [31:0] pad_word;
  logic [63:0] len_new;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] rot_dbl;
  logic [31:0] nb_val;
  logic [5:0]  rnd_next;

  assign out_o.valid        = out_valid_q;
  assign out_o.digest_front = out_front_q;
  assign out_o.digest_back  = out_back_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      md5_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          if (pop_entry_i.kind == md5_pkg::KIND_FINAL || widx_q == md5_pkg::LAST_WORD) begin
            state_d = md5_pkg::BK_PREP;
          end
        end
      end
      md5_pkg::BK_PREP:  state_d = md5_pkg::BK_ROUND;
      md5_pkg::BK_ROUND: begin
        if (rnd_q == md5_pkg::LAST_ROUND) begin
          state_d = md5_pkg::BK_FOLD;
        end
      end
      md5_pkg::BK_FOLD: begin
        if (!fin_q) begin
          state_d = md5_pkg::BK_IDLE;
        end else if (second_q) begin
          state_d = md5_pkg::BK_LENGTH;
        end else begin
          state_d = md5_pkg::BK_OUTPUT;
        end
      end
      md5_pkg::BK_LENGTH: state_d = md5_pkg::BK_PREP;
      md5_pkg::BK_OUTPUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = md5_pkg::BK_IDLE;
        end
      end
      default: state_d = md5_pkg::BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_ready_o = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      md5_pkg::BK_IDLE:   pop_ready_o = 1'b1;
      md5_pkg::BK_OUTPUT: out_load    = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign take = pop_ready_o && pop_valid_i;

  // Pad the last partial word and form the bit length
  always_comb begin
    pad_sh   = {pop_entry_i.nbytes, 3'b000};
    pad_word = (pop_entry_i.word & ~(32'hFFFF_FFFF << pad_sh)) | (md5_pkg::PAD_BYTE << pad_sh);
    len_new  = {wcount_q, pop_entry_i.nbytes, 3'b000};
  end

  // One MD5 round
  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    t_sum    = a_q + f_val + km_q;
    rot_dbl  = {t_sum, t_sum} << md5_pkg::md5_rot(rnd_q);
    nb_val   = b_q + rot_dbl[63:32];
    rnd_next = rnd_q + 6'd1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_pkg::BK_IDLE;
      widx_q      <= '0;
      wcount_q    <= '0;
      fin_q       <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q[0]  <= md5_pkg::IV_A;
      chain_q[1]  <= md5_pkg::IV_B;
      chain_q[2]  <= md5_pkg::IV_C;
      chain_q[3]  <= md5_pkg::IV_D;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        if (pop_entry_i.kind == md5_pkg::KIND_WORD) begin
          widx_q   <= widx_q + 4'd1;
          wcount_q <= wcount_q + 59'd1;
        end else begin
          fin_q    <= 1'b1;
          second_q <= (widx_q >= md5_pkg::LEN_LO_WORD);
        end
      end
      if (state_q == md5_pkg::BK_FOLD) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
      if (state_q == md5_pkg::BK_LENGTH) begin
        second_q <= 1'b0;
      end
      // Hand over the digest and start the next message
      if (out_load) begin
        widx_q      <= '0;
        wcount_q    <= '0;
        fin_q       <= 1'b0;
        chain_q[0]  <= md5_pkg::IV_A;
        chain_q[1]  <= md5_pkg::IV_B;
        chain_q[2]  <= md5_pkg::IV_C;
        chain_q[3]  <= md5_pkg::IV_D;
      end
    end
  end

  // Block store: message words, padding of the last word, and for a spilled
  // pad a second block of zeros with the bit length
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 16; k++) begin
      if (state_q == md5_pkg::BK_LENGTH) begin
        if (4'(k) == md5_pkg::LEN_LO_WORD) begin
          store_q[k] <= len_q[31:0];
        end else if (4'(k) == md5_pkg::LEN_HI_WORD) begin
          store_q[k] <= len_q[63:32];
        end else begin
          store_q[k] <= '0;
        end
      end else if (take) begin
        if (4'(k) == widx_q) begin
          if (pop_entry_i.kind == md5_pkg::KIND_WORD) begin
            store_q[k] <= pop_entry_i.word;
          end else begin
            store_q[k] <= pad_word;
          end
        end else if (pop_entry_i.kind == md5_pkg::KIND_FINAL && 4'(k) > widx_q) begin
          if (widx_q < md5_pkg::LEN_LO_WORD && 4'(k) == md5_pkg::LEN_LO_WORD) begin
            store_q[k] <= len_new[31:0];
          end else if (widx_q < md5_pkg::LEN_LO_WORD && 4'(k) == md5_pkg::LEN_HI_WORD) begin
            store_q[k] <= len_new[63:32];
          end else begin
            store_q[k] <= '0;
          end
        end
      end
    end
  end

  // Working variables, bit length and digest register
  always_ff @(posedge clk_i) begin
    if (take && pop_entry_i.kind == md5_pkg::KIND_FINAL) begin
      len_q <= len_new;
    end
    if (state_q == md5_pkg::BK_PREP) begin
      a_q   <= chain_q[0];
      b_q   <= chain_q[1];
      c_q   <= chain_q[2];
      d_q   <= chain_q[3];
      rnd_q <= '0;
      km_q  <= md5_pkg::md5_round_const('0) + store_q[md5_pkg::md5_msg_index('0)];
    end
    if (state_q == md5_pkg::BK_ROUND) begin
      a_q   <= d_q;
      b_q   <= nb_val;
      c_q   <= b_q;
      d_q   <= c_q;
      rnd_q <= rnd_next;
      km_q  <= md5_pkg::md5_round_const(rnd_next) + store_q[md5_pkg::md5_msg_index(rnd_next)];
    end
    if (out_load) begin
      out_front_q <= {md5_pkg::md5_bswap(chain_q[0]), md5_pkg::md5_bswap(chain_q[1])};
      out_back_q  <= {md5_pkg::md5_bswap(chain_q[2]), md5_pkg::md5_bswap(chain_q[3])};
    end
  end

endmodule

[sv/md5_message_digest.sv]
// MD5 digest top level: byte front end, word queue and compression back end.
//
// in_i carries one item per transaction: data_byte, byte_present (0 for an
// empty item) and message_end. out_o gives one transaction per message: the
// 128-bit digest as digest_front (bytes 0..7) and digest_back (bytes 8..15),
// first digest byte in the most significant position.
// The front accepts one item per cycle while the queue has room and no end
// entry is pending, and packs bytes into 32-bit words, which wait in a
// QueueDepth-entry queue. The back writes one word per cycle into its block
// store while idle and, on a full block, runs a load step, 64 rounds of one
// round per cycle and a fold step in the compression unit, taking no words
// until the fold is done. After an item with message_end the back pads the
// block, compresses it and loads the digest into the output register; when
// the padding spills into a second block, a length block is compressed too.
// The digest stays in an output register until taken; while it waits, the
// back holds the next digest and the queue fills, then in_i.ready drops.
// Reset loads the initial chaining words and empties the queue; no clearing
// pass is needed, so items are accepted right after reset.
module md5_message_digest #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  md5_pkg::md5_entry_t push_entry, pop_entry;

  md5_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  md5_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  md5_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

[sv/md5_checker.sv]
// Port checks for the MD5 digest block and their binding to the top level.
module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] digest_front_i,
  input logic [63:0] digest_back_i
);

  // Hold a stalled digest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("digest dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(digest_front_i) && $stable(digest_back_i))
    else $error("digest changed while stalled");

  // A sampled reset must clear the digest valid
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("digest valid during reset");

  // No digest when reset is released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("digest valid right after reset");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .digest_front_i (out_o.digest_front),
  .digest_back_i  (out_o.digest_back)
);
